[hdl/assert_macros.svh]
// Assertion macros for the load address predictor.
// Included by modules that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LAP_ASSERT_IMPL(label, ante, cons, msg) \
    `LAP_ASSERT(label, (ante) |-> (cons), msg)
`else
`define LAP_ASSERT(label, prop, msg)
`define LAP_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[hdl/lap_pkg.sv]
// Types, constants and codes shared by the load address predictor.
// No dependencies.
package lap_pkg;

    localparam int TABLE_ENTRIES   = 1024;
    localparam int IDX_W           = $clog2(TABLE_ENTRIES);
    localparam int HIST_W          = 32;
    localparam int TAG_W           = 16;
    localparam int ADDR_W          = 64;
    localparam int CONF_W          = 3;
    localparam int PROB_W          = 16;
    localparam int NUM_PROB_LEVELS = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic [1:0] {
        FUNC_HIST  = 2'd0,
        FUNC_TRAIN = 2'd1,
        FUNC_PRED  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_MASK = 3'd0,
        CFG_CONF_THR = 3'd1,
        CFG_PROB0    = 3'd2,
        CFG_PROB1    = 3'd3,
        CFG_PROB2    = 3'd4,
        CFG_PROB3    = 3'd5,
        CFG_PROB4    = 3'd6,
        CFG_PROB5    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [63:0]        pc;
        logic [ADDR_W-1:0]  actual_addr;
        logic [15:0]        random_value;
    } t_in_item;

    typedef struct packed {
        logic               tag_hit;
        logic               confident;
        logic [ADDR_W-1:0]  predicted_addr;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [ADDR_W-1:0]  addr;
        logic [CONF_W-1:0]  conf;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [TAG_W-1:0]                         key_mask;
        logic [CONF_W-1:0]                        conf_thr;
        logic [NUM_PROB_LEVELS-1:0][PROB_W-1:0]   prob;
    } t_cfg;

    typedef struct packed {
        logic   we;
        t_entry entry;
    } t_wb;

endpackage

[hdl/lap_table_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module lap_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 83
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lap_entry_update.sv]
// Entry modify step: train update and predict verdict for one table entry.
// Depends on lap_pkg.
module lap_entry_update (
    input  lap_pkg::t_entry              i_entry,
    input  lap_pkg::t_func               i_func,
    input  logic [lap_pkg::TAG_W-1:0]    i_tag,
    input  logic [lap_pkg::ADDR_W-1:0]   i_actual_addr,
    input  logic [15:0]                  i_random_value,
    input  lap_pkg::t_cfg                i_cfg,
    output lap_pkg::t_wb                 o_wb,
    output lap_pkg::t_out_item           o_result
);

    logic                        hit;
    logic                        prob_ok;
    logic [lap_pkg::PROB_W-1:0]  prob_sel;

    assign hit = (i_entry.tag == i_tag);

    always_comb begin
        prob_sel = '0;
        if (i_entry.conf < lap_pkg::CONF_W'(lap_pkg::NUM_PROB_LEVELS)) begin
            prob_sel = i_cfg.prob[i_entry.conf];
        end
    end

    assign prob_ok = (i_entry.conf < i_cfg.conf_thr)
                   && (i_entry.conf < lap_pkg::CONF_W'(lap_pkg::NUM_PROB_LEVELS))
                   && (i_random_value <= prob_sel);

    always_comb begin
        o_wb.we    = (i_func == lap_pkg::FUNC_TRAIN);
        o_wb.entry = i_entry;
        if (hit && (i_entry.addr == i_actual_addr)) begin
            if (prob_ok) begin
                o_wb.entry.conf = i_entry.conf + 1'b1;
            end
        end else if (hit && (i_entry.conf != '0)) begin
            o_wb.entry.conf = i_entry.conf - 1'b1;
        end else begin
            o_wb.entry.tag  = i_tag;
            o_wb.entry.addr = i_actual_addr;
            o_wb.entry.conf = '0;
        end
    end

    assign o_result.tag_hit        = hit;
    assign o_result.confident      = hit && (i_entry.conf >= i_cfg.conf_thr);
    assign o_result.predicted_addr = hit ? i_entry.addr : '0;

endmodule

[hdl/load_address_predictor.sv]
// Load address predictor top level: control, history, config and table.
// Depends on lap_pkg, lap_table_ram, lap_entry_update, assert_macros.svh.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+--------------------------
//  item    | i_item                              | start & !busy
//  result  | o_result                            | o_valid, one cycle
//  config  | i_cfg_idx, i_cfg_data               | i_cfg_we
//
// History and unused-code beats are handled in the idle state. Train and predict pass through
// the table read, then modify and write back in the execute state, with busy high there.
// Predict results appear on o_result the cycle after the execute state.
// After reset a clearing pass zeroes all 1024 table entries; busy is high.
// The result side cannot stall; results are never held.
`include "assert_macros.svh"
module load_address_predictor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  lap_pkg::t_in_item               i_item,
    output logic                            o_valid,
    output lap_pkg::t_out_item              o_result,
    input  logic                            i_cfg_we,
    input  logic [lap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lap_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lap_pkg::t_state                 r_state, n_state;
    logic [lap_pkg::IDX_W-1:0]       r_clr_idx;
    logic [lap_pkg::HIST_W-1:0]      r_hist;
    lap_pkg::t_cfg                   r_cfg;
    lap_pkg::t_in_item               r_item;
    logic [lap_pkg::IDX_W-1:0]       r_idx;
    logic [lap_pkg::TAG_W-1:0]       r_tag;
    logic                            r_valid;
    lap_pkg::t_out_item              r_result;

    logic                            accept;
    logic [lap_pkg::HIST_W-1:0]      hash;
    logic                            ram_we;
    logic [lap_pkg::IDX_W-1:0]       ram_waddr;
    lap_pkg::t_entry                 ram_wdata;
    lap_pkg::t_entry                 ram_rdata;
    lap_pkg::t_wb                    wb;
    lap_pkg::t_out_item              upd_result;

    assign accept = start && !busy;
    assign hash   = i_item.pc[lap_pkg::HIST_W-1:0] ^ r_hist;

    always_comb begin
        n_state   = r_state;
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = wb.entry;
        unique case (r_state)
            lap_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                if (r_clr_idx == '1) begin
                    n_state = lap_pkg::ST_IDLE;
                end
            end
            lap_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start && ((i_item.func == lap_pkg::FUNC_TRAIN)
                              || (i_item.func == lap_pkg::FUNC_PRED))) begin
                    n_state = lap_pkg::ST_EXEC;
                end
            end
            lap_pkg::ST_EXEC: begin
                ram_we  = wb.we;
                n_state = lap_pkg::ST_IDLE;
            end
            default: begin
                n_state = lap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lap_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_hist    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == lap_pkg::ST_EXEC) && (r_item.func == lap_pkg::FUNC_PRED);
            if (r_state == lap_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (accept && (i_item.func == lap_pkg::FUNC_HIST)) begin
                r_hist <= {i_item.pc[2], r_hist[lap_pkg::HIST_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_mask <= 16'hFC00;
            r_cfg.conf_thr <= 3'd3;
            r_cfg.prob     <= '1;
        end else if (i_cfg_we) begin
            unique case (lap_pkg::t_cfg_idx'(i_cfg_idx))
                lap_pkg::CFG_KEY_MASK: r_cfg.key_mask <= i_cfg_data;
                lap_pkg::CFG_CONF_THR: r_cfg.conf_thr <= i_cfg_data[lap_pkg::CONF_W-1:0];
                lap_pkg::CFG_PROB0, lap_pkg::CFG_PROB1, lap_pkg::CFG_PROB2,
                lap_pkg::CFG_PROB3, lap_pkg::CFG_PROB4, lap_pkg::CFG_PROB5: begin
                    r_cfg.prob[i_cfg_idx - lap_pkg::CFG_IDX_W'(lap_pkg::CFG_PROB0)]
                        <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_idx  <= hash[lap_pkg::IDX_W-1:0];
            r_tag  <= hash[lap_pkg::TAG_W-1:0] & r_cfg.key_mask;
        end
        if (r_state == lap_pkg::ST_EXEC) begin
            r_result <= upd_result;
        end
    end

    lap_table_ram #(
        .DEPTH (lap_pkg::TABLE_ENTRIES),
        .WIDTH (lap_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (hash[lap_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    lap_entry_update u_upd (
        .i_entry        (ram_rdata),
        .i_func         (r_item.func),
        .i_tag          (r_tag),
        .i_actual_addr  (r_item.actual_addr),
        .i_random_value (r_item.random_value),
        .i_cfg          (r_cfg),
        .o_wb           (wb),
        .o_result       (upd_result)
    );

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `LAP_ASSERT_IMPL(a_clear_writes, r_state == lap_pkg::ST_CLEAR, ram_we && busy,
        "clearing pass must write and hold off beats")
    `LAP_ASSERT_IMPL(a_valid_after_exec, o_valid, $past(r_state == lap_pkg::ST_EXEC),
        "result strobe without a preceding execute cycle")
    `LAP_ASSERT(a_valid_single, o_valid |=> !o_valid,
        "result strobes on consecutive cycles")
    `LAP_ASSERT(a_accept_exec,
        (accept && (i_item.func == lap_pkg::FUNC_PRED)) |=> (r_state == lap_pkg::ST_EXEC),
        "predict beat did not enter execute")

endmodule

[bench/tb_load_address_predictor.sv]
// Self-checking bench for load_address_predictor: directed and random item traffic
// against a behavioural copy of the prediction table, with config changes between phases.
// Depends on lap_pkg and the load_address_predictor RTL.
module tb_load_address_predictor;
    timeunit 1ns;
    timeprecision 1ps;

    import lap_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int POOL_SIZE       = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_in_item              i_item     = '0;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    load_address_predictor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Table mirror and its configuration
    logic [HIST_W-1:0] path_hist;
    logic [TAG_W-1:0]  ent_tag  [TABLE_ENTRIES];
    logic [ADDR_W-1:0] ent_addr [TABLE_ENTRIES];
    logic [CONF_W-1:0] ent_conf [TABLE_ENTRIES];
    logic [TAG_W-1:0]  cfg_mask;
    logic [CONF_W-1:0] cfg_thr;
    logic [PROB_W-1:0] cfg_prob [NUM_PROB_LEVELS];

    t_out_item         pending_predictions [$];
    int                n_errors   = 0;
    int                n_sent     = 0;
    int                n_checked  = 0;
    int                n_settings = 0;
    int                stall_count = 0;

    logic [63:0]       pc_pool   [POOL_SIZE];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    function automatic void clear_table_model();
        path_hist = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            ent_tag[k]  = '0;
            ent_addr[k] = '0;
            ent_conf[k] = '0;
        end
        cfg_mask = 16'hFC00;
        cfg_thr  = 3'd3;
        for (int k = 0; k < NUM_PROB_LEVELS; k++) cfg_prob[k] = 16'hFFFF;
    endfunction

    // Applies one accepted beat to the mirror; returns 1 with the lookup when a result is due.
    function automatic bit lookup_and_train(input t_in_item it, output t_out_item res);
        logic [HIST_W-1:0] h;
        logic [IDX_W-1:0]  idx;
        logic [TAG_W-1:0]  tag;
        logic [CONF_W-1:0] c;
        logic              hit;
        res = '0;
        h   = it.pc[HIST_W-1:0] ^ path_hist;
        idx = IDX_W'(h % TABLE_ENTRIES);
        tag = h[TAG_W-1:0] & cfg_mask;
        hit = (ent_tag[idx] == tag);
        case (it.func)
            FUNC_HIST: begin
                path_hist = {it.pc[2], path_hist[HIST_W-1:1]};
                return 1'b0;
            end
            FUNC_TRAIN: begin
                c = ent_conf[idx];
                if (hit && ent_addr[idx] == it.actual_addr) begin
                    if (c < cfg_thr && c < NUM_PROB_LEVELS && it.random_value <= cfg_prob[c])
                        ent_conf[idx] = c + 1'b1;
                end else if (hit && c != 0) begin
                    ent_conf[idx] = c - 1'b1;
                end else begin
                    ent_tag[idx]  = tag;
                    ent_addr[idx] = it.actual_addr;
                    ent_conf[idx] = '0;
                end
                return 1'b0;
            end
            FUNC_PRED: begin
                res.tag_hit        = hit;
                res.confident      = hit && (ent_conf[idx] >= cfg_thr);
                res.predicted_addr = hit ? ent_addr[idx] : '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Result checker and mirror update, all on pre-edge values
    always @(posedge i_clk) begin
        t_out_item exp_res;
        t_out_item new_res;
        if (!i_rst_n) begin
            clear_table_model();
        end else begin
            if (o_valid === 1'b1) begin
                if (pending_predictions.size() == 0) begin
                    $display("%0t unexpected result beat: got %p", $realtime, o_result);
                    n_errors++;
                end else begin
                    exp_res = pending_predictions.pop_front();
                    n_checked++;
                    if (o_result.tag_hit !== exp_res.tag_hit) begin
                        $display("%0t tag_hit mismatch: expected %0b actual %0b",
                                 $realtime, exp_res.tag_hit, o_result.tag_hit);
                        n_errors++;
                    end
                    if (o_result.confident !== exp_res.confident) begin
                        $display("%0t confident mismatch: expected %0b actual %0b",
                                 $realtime, exp_res.confident, o_result.confident);
                        n_errors++;
                    end
                    if (o_result.predicted_addr !== exp_res.predicted_addr) begin
                        $display("%0t predicted_addr mismatch: expected %h actual %h",
                                 $realtime, exp_res.predicted_addr, o_result.predicted_addr);
                        n_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_MASK: cfg_mask = i_cfg_data[TAG_W-1:0];
                    CFG_CONF_THR: cfg_thr  = i_cfg_data[CONF_W-1:0];
                    default:      cfg_prob[i_cfg_idx - CFG_PROB0] = i_cfg_data[PROB_W-1:0];
                endcase
            end
            if (start && busy === 1'b0) begin
                if (lookup_and_train(i_item, new_res))
                    pending_predictions.push_back(new_res);
            end
        end
    end

    always @(posedge i_clk) begin
        if (start && busy === 1'b0) stall_count <= 0;
        else                         stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_CYCLES) begin
            $display("%0t watchdog: no beat accepted for %0d cycles", $realtime, stall_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_func f, logic [63:0] pc, logic [ADDR_W-1:0] addr,
                                           logic [15:0] rnd);
        t_in_item it;
        it.func         = f;
        it.pc           = pc;
        it.actual_addr  = addr;
        it.random_value = rnd;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
    endtask

    task automatic pause_sender(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every expected beat has come and the write-back has retired
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_predictions.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx r, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] mask, input logic [2:0] thr,
                             input logic [15:0] probs [NUM_PROB_LEVELS]);
        settle();
        write_reg(CFG_KEY_MASK, mask);
        write_reg(CFG_CONF_THR, {13'd0, thr});
        for (int k = 0; k < NUM_PROB_LEVELS; k++)
            write_reg(t_cfg_idx'(CFG_PROB0 + k), probs[k]);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_cleared_table();
        send_item(make_item(FUNC_PRED, 64'd0, '0, '0));
        send_item(make_item(FUNC_PRED, '1, '1, '1));
        send_item(make_item(FUNC_PRED, 64'h3FF, '0, '0));
        send_item(make_item(FUNC_NOP, 64'hFFFF_FFFF_0000_0000, '1, '1));
        send_item(make_item(FUNC_PRED, 64'd0, '0, '0));
    endtask

    task automatic test_history_and_nop();
        send_item(make_item(FUNC_HIST, 64'h4, '0, '0));
        send_item(make_item(FUNC_HIST, 64'h0, '1, '1));
        send_item(make_item(FUNC_HIST, '1, '0, '0));
        send_item(make_item(FUNC_NOP, '1, '1, '1));
        send_item(make_item(FUNC_PRED, 64'd0, '0, '0));
    endtask

    task automatic test_confidence_training();
        logic [63:0] pc;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        pc     = 64'hDEAD_BEEF_0000_1234;
        addr_a = '1;
        addr_b = 64'h0000_0000_8000_0040;
        send_item(make_item(FUNC_TRAIN, pc, addr_a, 16'h0000));
        repeat (3) send_item(make_item(FUNC_TRAIN, pc, addr_a, 16'hFFFF));
        send_item(make_item(FUNC_PRED, pc, '0, '0));
        repeat (4) send_item(make_item(FUNC_TRAIN, pc, addr_b, 16'h0000));
        send_item(make_item(FUNC_PRED, pc, '0, '0));
    endtask

    task automatic test_threshold_extremes();
        logic [15:0] probs [NUM_PROB_LEVELS];
        logic [63:0] pc;
        pc = 64'h0123_4567_89AB_C5A0;
        foreach (probs[k]) probs[k] = 16'hFFFF;
        configure(16'hFFFF, 3'd7, probs);
        repeat (8) send_item(make_item(FUNC_TRAIN, pc, 64'h55, 16'hFFFF));
        send_item(make_item(FUNC_PRED, pc, '0, '0));
        configure(16'hFFFF, 3'd6, probs);
        send_item(make_item(FUNC_PRED, pc, '0, '0));
        foreach (probs[k]) probs[k] = 16'h0000;
        configure(16'h0000, 3'd0, probs);
        send_item(make_item(FUNC_PRED, 64'h0000_0000_0000_0AA8, '0, '0));
        configure(16'h0000, 3'd2, probs);
        send_item(make_item(FUNC_TRAIN, 64'h0000_0000_0000_0AA8, 64'h99, 16'h0001));
        send_item(make_item(FUNC_TRAIN, 64'h0000_0000_0000_0AA8, 64'h99, 16'h0000));
        send_item(make_item(FUNC_PRED, 64'h0000_0000_0000_0AA8, '0, '0));
    endtask

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(2))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item();
        int r;
        int j;
        t_in_item it;
        r = $urandom_range(99);
        j = $urandom_range(POOL_SIZE - 1);
        if (r < 8)       it.func = FUNC_HIST;
        else if (r < 55) it.func = FUNC_TRAIN;
        else if (r < 95) it.func = FUNC_PRED;
        else             it.func = FUNC_NOP;
        it.pc = ($urandom_range(19) == 0) ? {$urandom, $urandom} : pc_pool[j];
        r = $urandom_range(99);
        if (r < 75)      it.actual_addr = addr_pool[j];
        else if (r < 90) it.actual_addr = addr_pool[(j + 1) % POOL_SIZE];
        else             it.actual_addr = {$urandom, $urandom};
        it.random_value = 16'($urandom);
        return it;
    endfunction

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        logic [15:0] probs [NUM_PROB_LEVELS];
        logic [15:0] mask;
        foreach (probs[k]) probs[k] = pick_prob();
        case ($urandom_range(3))
            0:       mask = 16'hFFFF;
            1:       mask = 16'hFC00;
            2:       mask = 16'h0000;
            default: mask = 16'($urandom);
        endcase
        configure(mask, 3'($urandom_range(7)), probs);
        foreach (pc_pool[k]) begin
            pc_pool[k]   = {$urandom, $urandom};
            addr_pool[k] = {$urandom, $urandom};
        end
        for (int n = 0; n < n_items; n++) begin
            pause_sender(idle_pct);
            if ($urandom_range(49) == 0) settle();
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_history_and_nop();
        test_confidence_training();
        test_threshold_extremes();
        test_random_traffic(0, 160);
        test_random_traffic(54, 160);
        test_random_traffic(0, 160);
        test_random_traffic(8, 170);

        settle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d item beats and %0d predict results over %0d config settings,",
                 n_sent, n_checked, n_settings);
        $display("from the cleared table through threshold extremes to random mixed traffic.");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
